// ===== hdl/key_hash_to_slot_unit_macros.svh =====
// Assertion macros shared by the key hash to slot unit RTL.
// Included by hdl/key_hash_to_slot_unit.sv; has no dependencies of its own.
`ifndef KEY_HASH_TO_SLOT_UNIT_MACROS_SVH
`define KEY_HASH_TO_SLOT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define KHS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("key hash to slot unit: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define KHS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("key hash to slot unit: next-cycle check failed");

`endif

// ===== hdl/khs_pkg.sv =====
// Package of the key hash to slot unit: payload types, widths and state codes.
// No dependencies; imported by hdl/key_hash_to_slot_unit.sv.
package khs_pkg;

    localparam int HASH_BITS       = 32;
    localparam int SLOT_BITS       = 16;
    localparam int SLOT_INDEX_BITS = 16;
    localparam int STEP_CNT_BITS   = $clog2(HASH_BITS);

    // Low SLOT_INDEX_BITS bits of the slot, kept to the 16-bit field.
    localparam logic [SLOT_BITS-1:0] SLOT_MASK =
        SLOT_BITS'(((33'(1)) << SLOT_INDEX_BITS) - 33'(1));

    localparam logic [HASH_BITS-1:0] BINARY_SEED = '1;
    localparam logic [HASH_BITS-1:0] STRING_SEED = '0;
    localparam logic [HASH_BITS-1:0] ELF_TOP     = 32'hF000_0000;

    // Configuration register indexes.
    localparam logic CFG_STRING_MODE = 1'b0;
    localparam logic CFG_SLOT_COUNT  = 1'b1;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       last_byte;
    } khs_in_t;

    typedef struct packed {
        logic [SLOT_BITS-1:0] slot_index;
        logic [HASH_BITS-1:0] hash_value;
    } khs_out_t;

    // One byte of the ELF hash.
    function automatic logic [HASH_BITS-1:0] elf_fold(
        input logic [HASH_BITS-1:0] h,
        input logic [7:0]           b
    );
        logic [HASH_BITS-1:0] t;
        logic [HASH_BITS-1:0] top;
        t   = (h << 4) + HASH_BITS'(b);
        top = t & ELF_TOP;
        t   = t ^ (top >> 24);
        return t & ~top;
    endfunction

endpackage

// ===== hdl/key_hash_to_slot_unit.sv =====
// Top level of the key hash to slot unit: byte-wise hash and iterative modulo.
// Depends on hdl/khs_pkg.sv and hdl/key_hash_to_slot_unit_macros.svh.
//
//  Channel  | Direction | Handshake           | Payload
//  s_       | in        | s_valid / s_ready   | khs_in_t  : key_byte, last_byte
//  m_       | out       | m_valid / m_ready   | khs_out_t : slot_index, hash_value
//  cfg_     | in        | cfg_wr_en (no wait) | cfg_index, cfg_wr_data
//
// A byte that ends no key is folded as it is taken; the next byte can follow at once.
// A last byte is folded as it is taken; then the shared restoring subtractor, in ST_DIV,
// takes one hash bit per cycle to form the remainder by slot_count, and ST_DONE loads
// the output register, with the input not ready throughout.
// The result then sits in the output register, and the next key's bytes are taken while it
// waits; a stalled result only holds the next key's load, with the input not ready meanwhile.
// Reset (aresetn low, synchronous) selects binary mode, a slot count of one, and key start.
`include "key_hash_to_slot_unit_macros.svh"

module key_hash_to_slot_unit
    import khs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  khs_in_t              s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output khs_out_t             m_item,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [SLOT_BITS-1:0] cfg_wr_data
);

    // Configuration registers.
    logic                 string_mode_reg;
    logic [SLOT_BITS-1:0] slot_count_reg;

    // Hash state for the key in progress.
    logic [HASH_BITS-1:0] acc_reg, acc_next;
    logic                 ended_reg, ended_next;
    logic                 key_start_reg;

    // Sequencer and the shared subtract unit.
    logic [1:0]               state_reg, state_next;
    logic [STEP_CNT_BITS-1:0] step_reg;
    logic [HASH_BITS-1:0]     dividend_reg;
    logic [SLOT_BITS-1:0]     rem_reg;
    logic [SLOT_BITS:0]       rem_shift;
    logic [SLOT_BITS:0]       rem_diff;
    logic                     rem_ge;
    logic [SLOT_BITS-1:0]     rem_next;

    // Output register.
    logic     m_valid_reg;
    khs_out_t m_item_reg;

    logic accept_in;
    logic base_ended;
    logic [HASH_BITS-1:0] base_acc;
    logic out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept_in = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            string_mode_reg <= 1'b0;
            slot_count_reg  <= SLOT_BITS'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_STRING_MODE: string_mode_reg <= cfg_wr_data[0];
                CFG_SLOT_COUNT:  slot_count_reg  <= cfg_wr_data;
                default:         ;
            endcase
        end
    end

    // Byte fold. At key start the accumulator restarts from the seed of the
    // current mode; the mode is sampled on every byte. In string mode a zero
    // byte ends the string and later bytes leave the hash alone.
    always_comb begin
        base_acc   = key_start_reg ? (string_mode_reg ? STRING_SEED : BINARY_SEED) : acc_reg;
        base_ended = key_start_reg ? 1'b0 : ended_reg;
        acc_next   = base_acc;
        ended_next = base_ended;
        if (string_mode_reg) begin
            if (!base_ended) begin
                if (s_item.key_byte == 8'd0) begin
                    ended_next = 1'b1;
                end else begin
                    acc_next = elf_fold(base_acc, s_item.key_byte);
                end
            end
        end else begin
            acc_next = (base_acc << 5) + base_acc + HASH_BITS'(s_item.key_byte);
        end
    end

    // One restoring division step: bring in the next hash bit, subtract if it fits.
    always_comb begin
        rem_shift = {rem_reg, dividend_reg[HASH_BITS-1]};
        rem_diff  = rem_shift - {1'b0, slot_count_reg};
        rem_ge    = (rem_shift >= {1'b0, slot_count_reg});
        rem_next  = rem_ge ? rem_diff[SLOT_BITS-1:0] : rem_shift[SLOT_BITS-1:0];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept_in && s_item.last_byte) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (step_reg == STEP_CNT_BITS'(HASH_BITS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            key_start_reg <= 1'b1;
            ended_reg     <= 1'b0;
            acc_reg       <= BINARY_SEED;
            step_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept_in) begin
                acc_reg       <= acc_next;
                ended_reg     <= s_item.last_byte ? 1'b0 : ended_next;
                key_start_reg <= s_item.last_byte;
            end
            if (state_reg == ST_DIV) begin
                step_reg <= step_reg + STEP_CNT_BITS'(1);
            end else begin
                step_reg <= '0;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Divider data path and result payload; no reset needed.
    always_ff @(posedge aclk) begin
        if (accept_in && s_item.last_byte) begin
            dividend_reg <= acc_next;
            rem_reg      <= '0;
        end else if (state_reg == ST_DIV) begin
            dividend_reg <= dividend_reg << 1;
            rem_reg      <= rem_next;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_item_reg.hash_value <= acc_reg;
            m_item_reg.slot_index <= (slot_count_reg == '0) ? '0 : (rem_reg & SLOT_MASK);
        end
    end

    // A last byte starts the modulo from step zero on the next cycle.
    `KHS_ASSERT_NEXT(a_last_starts_div, aclk, aresetn, accept_in && s_item.last_byte, state_reg == ST_DIV && step_reg == '0)
    // Other bytes keep the unit free for the following byte.
    `KHS_ASSERT_NEXT(a_mid_byte_stays_idle, aclk, aresetn, accept_in && !s_item.last_byte, state_reg == ST_IDLE && !key_start_reg)
    // The partial remainder never reaches the divisor.
    `KHS_ASSERT_SAME(a_rem_below_div, aclk, aresetn, state_reg == ST_DIV && slot_count_reg != '0, rem_reg < slot_count_reg)
    // A delivered slot lies inside the index.
    `KHS_ASSERT_SAME(a_slot_in_range, aclk, aresetn, m_valid_reg && slot_count_reg != '0, m_item_reg.slot_index < slot_count_reg)

endmodule

// ===== bench/key_hash_to_slot_unit_test.sv =====
// Self-checking bench for key_hash_to_slot_unit: directed and random keys in both hash modes.
// Depends on hdl/khs_pkg.sv for the payload types and register indexes.
// Checks both result fields of every key against a predictor kept inside this bench.
module key_hash_to_slot_unit_test
    import khs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The slowest correct run is about 1400 keys of one byte each, every one holding the block
    // through the modulo plus sender gaps and receiver stalls, so this limit leaves a wide margin.
    localparam int CYCLE_LIMIT    = 500000;
    // Long enough for a last byte to run through the modulo before the block counts as idle.
    localparam int SETTLE_CYCLES  = 40;
    localparam int RESULT_WAIT    = 5000;
    localparam int RANDOM_BYTES   = 1220;
    localparam int RANDOM_PHASES  = 12;
    localparam int IDLE_PERCENT   = 15;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    khs_in_t              s_item      = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    khs_out_t             m_item;
    logic                 cfg_wr_en   = 1'b0;
    logic                 cfg_index   = CFG_STRING_MODE;
    logic [SLOT_BITS-1:0] cfg_wr_data = '0;

    // While this is set, neither side idles. It gives the long stretch of back-to-back traffic.
    logic steady = 1'b0;

    // Predictor state. It mirrors the block's registers and running hash.
    logic                 str_mode     = 1'b0;
    logic [SLOT_BITS-1:0] slot_div     = 16'd1;
    logic [HASH_BITS-1:0] run_hash     = '1;
    logic                 string_done  = 1'b0;
    logic                 at_key_start = 1'b1;

    // Slots and hashes still owed by the block, oldest first.
    khs_out_t expected_slots[$];

    int cycle_count     = 0;
    int report_count    = 0;
    int mismatch_count  = 0;
    int unexpected_count = 0;
    int leftover_count  = 0;
    int folded_bytes    = 0;
    int keys_string     = 0;
    int keys_binary     = 0;
    int results_seen    = 0;
    int settings_done   = 0;

    key_hash_to_slot_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    // Folds one accepted byte into the running hash. The mode is taken per byte, so a mode
    // change in the middle of a key folds the later bytes with the new hash. In string mode
    // a zero byte ends the string and every byte after it is skipped. On the last byte the
    // expected slot and hash are queued and the next byte starts a fresh key.
    task automatic hash_key_byte(input logic [7:0] key_byte, input logic last_byte);
        logic [HASH_BITS-1:0] shifted;
        logic [HASH_BITS-1:0] top_bits;
        khs_out_t             owed;
        if (at_key_start) begin
            run_hash     = str_mode ? '0 : '1;
            string_done  = 1'b0;
            at_key_start = 1'b0;
        end
        if (str_mode) begin
            if (!string_done) begin
                if (key_byte == 8'd0) begin
                    string_done = 1'b1;
                end else begin
                    shifted  = (run_hash << 4) + HASH_BITS'(key_byte);
                    top_bits = shifted & 32'hF000_0000;
                    shifted  = shifted ^ (top_bits >> 24);
                    run_hash = shifted & ~top_bits;
                    folded_bytes++;
                end
            end
        end else begin
            run_hash = run_hash * 33 + HASH_BITS'(key_byte);
            folded_bytes++;
        end
        if (last_byte) begin
            owed.hash_value = run_hash;
            // A slot count of zero gives slot zero rather than a division by zero.
            owed.slot_index = (slot_div != '0) ?
                SLOT_BITS'(run_hash % HASH_BITS'(slot_div)) & SLOT_MASK : '0;
            expected_slots.push_back(owed);
            if (str_mode)
                keys_string++;
            else
                keys_binary++;
            at_key_start = 1'b1;
            string_done  = 1'b0;
        end
    endtask

    // Offers one byte and returns at the edge that accepts it. Valid stays high on return so
    // that the next byte can follow with no bubble; quiesce lowers it.
    task automatic send_byte(input logic [7:0] key_byte, input logic last_byte);
        if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_item.key_byte  <= key_byte;
        s_item.last_byte <= last_byte;
        do
            @(posedge aclk);
        while (!s_ready);
        hash_key_byte(key_byte, last_byte);
    endtask

    // Stops the sender, waits until every owed result has come back, then lets the modulo
    // stage run out. A byte that ends no key gives no result, so the extra cycles matter.
    task automatic quiesce();
        int waited;
        waited  = 0;
        s_valid <= 1'b0;
        while (expected_slots.size() != 0 && waited < RESULT_WAIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes both registers, mode first and then slot count, on back-to-back edges while the block is idle.
    task automatic write_config(input logic mode, input logic [SLOT_BITS-1:0] count);
        quiesce();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_STRING_MODE;
        cfg_wr_data <= SLOT_BITS'(mode);
        @(posedge aclk);
        cfg_index   <= CFG_SLOT_COUNT;
        cfg_wr_data <= count;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        str_mode = mode;
        slot_div = count;
        settings_done++;
    endtask

    // Reset leaves binary mode and one slot, so every slot is zero and only the hash varies.
    // The keys reach the byte extremes and a key of three bytes.
    task automatic test_binary_defaults();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    // String mode with the largest slot count: the empty string, a zero byte that ends the
    // string with more bytes behind it, and a long key that drives the top nibble of the
    // hash so the folding-back path is taken.
    task automatic test_string_keys();
        write_config(1'b1, 16'hFFFF);
        send_byte(8'h00, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hFD, 1'b0);
        send_byte(8'hFC, 1'b0);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hFA, 1'b0);
        send_byte(8'hF9, 1'b0);
        send_byte(8'hF8, 1'b1);
    endtask

    // The mode is switched halfway through a key, once each way. The block is idle at the
    // switch because only bytes that end no key have been sent.
    task automatic test_mode_switch_in_key();
        write_config(1'b0, 16'd1000);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        write_config(1'b1, 16'd1000);
        send_byte(8'h56, 1'b1);
        send_byte(8'h9A, 1'b0);
        write_config(1'b0, 16'd1000);
        send_byte(8'hBC, 1'b1);
    endtask

    task automatic test_zero_slot_count();
        write_config(1'b0, 16'd0);
        send_byte(8'hAB, 1'b1);
    endtask

    // Random keys over a series of settings. Most keys are short; one in twenty is long.
    // In string mode the bytes are nonzero except for an occasional early zero, so most keys
    // are hashed in full and a few have a tail that is skipped. The first phase runs with no
    // idling on either side; the first few settings hit the slot count extremes.
    task automatic test_random_keys();
        int                   phase;
        int                   phase_goal;
        int                   len;
        int                   zero_at;
        logic                 mode;
        logic [SLOT_BITS-1:0] count;
        logic [7:0]           key_byte;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            mode = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
            case (phase)
                0: count = 16'hFFFF;
                1: count = 16'd1;
                2: count = 16'd0;
                3: count = 16'd2;
                default: begin
                    if ($urandom_range(0, 1) == 0)
                        count = SLOT_BITS'($urandom_range(1, 64));
                    else
                        count = SLOT_BITS'($urandom_range(0, 65535));
                end
            endcase
            write_config(mode, count);
            steady = (phase == 0);
            phase_goal = folded_bytes + RANDOM_BYTES / RANDOM_PHASES;
            while (folded_bytes < phase_goal) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 48)
                                                    : $urandom_range(1, 12);
                zero_at = (mode && $urandom_range(0, 6) == 0) ? $urandom_range(0, len - 1)
                                                              : len;
                for (int j = 0; j < len; j++) begin
                    if (!mode)
                        key_byte = 8'($urandom_range(0, 255));
                    else if (j == zero_at)
                        key_byte = 8'h00;
                    else
                        key_byte = 8'($urandom_range(1, 255));
                    send_byte(key_byte, j == len - 1);
                end
            end
        end
        steady = 1'b0;
    endtask

    // Result side: every accepted item is checked field by field against the oldest
    // expectation. The ready for the next edge is drawn at the same edge.
    always @(posedge aclk) begin
        khs_out_t owed;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_slots.size() == 0) begin
                unexpected_count++;
                if (report_count < 10) begin
                    report_count++;
                    $display("unexpected result: slot %0d hash %08h",
                             m_item.slot_index, m_item.hash_value);
                end
            end else begin
                owed = expected_slots.pop_front();
                if (m_item.slot_index !== owed.slot_index
                        || m_item.hash_value !== owed.hash_value) begin
                    mismatch_count++;
                    if (report_count < 10) begin
                        report_count++;
                        $display("result mismatch: slot exp %0d got %0d, hash exp %08h got %08h",
                                 owed.slot_index, m_item.slot_index,
                                 owed.hash_value, m_item.hash_value);
                    end
                end
            end
        end
        m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("FAILURE");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_binary_defaults();
        test_string_keys();
        test_mode_switch_in_key();
        test_zero_slot_count();
        test_random_keys();

        quiesce();
        leftover_count = expected_slots.size();
        $display("Hashed %0d string keys and %0d binary keys (%0d bytes folded) under %0d settings.",
                 keys_string, keys_binary, folded_bytes, settings_done);
        $display("Results checked: %0d; mismatches %0d, unexpected %0d, missing %0d.",
                 results_seen, mismatch_count, unexpected_count, leftover_count);
        if (mismatch_count == 0 && unexpected_count == 0 && leftover_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
